// File: rtl/ibwt_pkg.sv
// Shared constants, types and helpers of the inverse BWT block decoder.
package ibwt_pkg;

  localparam int BLOCK_MAX = 65536;
  localparam int SYMBOLS   = 256;

  localparam int ROW_W = $clog2(BLOCK_MAX);
  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int CNT_W = $clog2(BLOCK_MAX) + 1;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
  } cnt_req_t;

  function automatic logic [SYM_W-1:0] sat_symbol(input logic [7:0] sym);
    logic [SYM_W-1:0] res;
    if ({1'b0, sym} >= 9'(SYMBOLS)) begin
      res = SYM_W'(SYMBOLS - 1);
    end else begin
      res = SYM_W'(sym);
    end
    return res;
  endfunction

endpackage

// File: rtl/ibwt_count_table.sv
// Per-symbol count and cumulative table with per-entry valid bits.
module ibwt_count_table
  import ibwt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_req_t         req_i,
  output logic [CNT_W-1:0] rd_data_o
);

  logic [CNT_W-1:0] mem [SYMBOLS];
  logic [CNT_W-1:0] rdata_q;
  logic [SYMBOLS-1:0] valid_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr] && !req_i.clear;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rdata_q : '0;

endmodule

// File: rtl/inverse_bwt_block_decoder_top.sv
// Top level of the inverse Burrows-Wheeler block decoder.
//
// The input stream carries two kinds of request, chosen by s_axis_tuser_i.
// A load request (tuser 0) stores one transformed byte; tlast marks the last
// load of a block and tdata carries the primary row with it. An emit request
// (tuser 1) returns the next reconstructed byte with its position, counting
// down from the block length minus one; tlast on the output marks position 0.
// Emit requests with no decoded block pending produce no output.
// A load first reads the symbol count, then writes the row and count
// memories. The last load then closes the block and, unless it is empty,
// sweeps all 256 count entries to turn the counts into cumulative offsets in
// place; no request is taken meanwhile. An emit reads the row memory and then
// the cumulative table in series; its result is written to the output
// register once that register is free.
// A stalled output holds its result in the output register; the next request
// is still accepted, and a new result waits until the register is free.
// Reset returns the block to the idle state with an empty block; the row
// memory keeps no reset value and the count table is marked empty.
module inverse_bwt_block_decoder_top
  import ibwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // symbol [7:0], primary_index [23:8]
  input  logic        s_axis_tuser_i,  // kind
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // value [7:0], position [23:8]
  output logic        m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_READY,
    ST_LOAD_WR,
    ST_CLOSE,
    ST_SWEEP,
    ST_EMIT_ROW,
    ST_EMIT_CUM
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOAD,
    PH_EMIT
  } phase_e;

  localparam int ROWD_W = SYM_W + ROW_W;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [CNT_W-1:0] length_q, length_d;
  logic [CNT_W-1:0] sentinel_q, sentinel_d;
  logic [CNT_W-1:0] walk_q, walk_d;
  logic [CNT_W-1:0] emit_left_q, emit_left_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic [SYM_W-1:0] sweep_idx_q, sweep_idx_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic [15:0]      primary_q, primary_d;
  logic             last_q, last_d;
  logic [SYM_W-1:0] b_q, b_d;
  logic [ROW_W-1:0] r_q, r_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_value_q, out_value_d;
  logic [15:0] out_pos_q, out_pos_d;
  logic        out_last_q, out_last_d;

  cnt_req_t         cnt_req;
  logic [CNT_W-1:0] cnt_rdata;

  logic [ROWD_W-1:0] row_mem [BLOCK_MAX];
  logic [ROWD_W-1:0] row_rdata_q;
  logic              row_we;
  logic              row_re;
  logic [ROW_W-1:0]  row_waddr;
  logic [ROWD_W-1:0] row_wdata;

  logic [CNT_W-1:0] len_v;
  logic [CNT_W-1:0] next_v;
  logic [CNT_W-1:0] pos_v;
  logic             in_block;

  ibwt_count_table u_count_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cnt_req),
    .rd_data_o (cnt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rdata_q <= row_mem[walk_q[ROW_W-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    length_d    = length_q;
    sentinel_d  = sentinel_q;
    walk_d      = walk_q;
    emit_left_d = emit_left_q;
    acc_d       = acc_q;
    sweep_idx_d = sweep_idx_q;
    sym_d       = sym_q;
    primary_d   = primary_q;
    last_d      = last_q;
    b_d         = b_q;
    r_d         = r_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    cnt_req     = '0;
    row_we      = 1'b0;
    row_re      = 1'b0;
    row_waddr   = length_q[ROW_W-1:0];
    row_wdata   = {sym_q, cnt_rdata[ROW_W-1:0]};
    len_v       = length_q;
    in_block    = 1'b0;
    next_v      = '0;
    pos_v       = emit_left_q - CNT_W'(1);

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_READY: begin
        if (s_axis_tvalid_i) begin
          if (!s_axis_tuser_i) begin
            if (phase_q != PH_LOAD) begin
              cnt_req.clear = 1'b1;
              len_v         = '0;
              length_d      = '0;
              emit_left_d   = '0;
              phase_d       = PH_LOAD;
            end
            sym_d     = sat_symbol(s_axis_tdata_i[7:0]);
            primary_d = s_axis_tdata_i[23:8];
            last_d    = s_axis_tlast_i;
            if (len_v < CNT_W'(BLOCK_MAX)) begin
              cnt_req.rd_en   = 1'b1;
              cnt_req.rd_addr = sat_symbol(s_axis_tdata_i[7:0]);
              state_d         = ST_LOAD_WR;
            end else if (s_axis_tlast_i) begin
              state_d = ST_CLOSE;
            end
          end else if (phase_q == PH_EMIT) begin
            row_re  = 1'b1;
            state_d = ST_EMIT_ROW;
          end
        end
      end
      ST_LOAD_WR: begin
        row_we          = 1'b1;
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_addr = sym_q;
        cnt_req.wr_data = cnt_rdata + CNT_W'(1);
        length_d        = length_q + CNT_W'(1);
        state_d         = last_q ? ST_CLOSE : ST_READY;
      end
      ST_CLOSE: begin
        if (length_q == '0) begin
          phase_d = PH_IDLE;
          state_d = ST_READY;
        end else begin
          if (CNT_W'(primary_q) < length_q) begin
            sentinel_d = CNT_W'(primary_q);
          end else begin
            sentinel_d = length_q - CNT_W'(1);
          end
          walk_d          = sentinel_d;
          emit_left_d     = length_q;
          acc_d           = '0;
          sweep_idx_d     = '0;
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = '0;
          state_d         = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_addr = sweep_idx_q;
        cnt_req.wr_data = acc_q;
        acc_d           = acc_q + cnt_rdata;
        if (sweep_idx_q == SYM_W'(SYMBOLS - 1)) begin
          phase_d = PH_EMIT;
          state_d = ST_READY;
        end else begin
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = sweep_idx_q + SYM_W'(1);
          sweep_idx_d     = sweep_idx_q + SYM_W'(1);
        end
      end
      ST_EMIT_ROW: begin
        in_block = walk_q < length_q;
        if (in_block) begin
          b_d = row_rdata_q[ROWD_W-1:ROW_W];
          r_d = row_rdata_q[ROW_W-1:0];
        end else begin
          b_d = '0;
          r_d = '0;
        end
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = b_d;
        state_d         = ST_EMIT_CUM;
      end
      ST_EMIT_CUM: begin
        if (!out_valid_q || m_axis_tready_i) begin
          if (walk_q == sentinel_q) begin
            next_v = '0;
          end else begin
            next_v = CNT_W'(r_q) + cnt_rdata;
            if (b_q == '0 && walk_q < sentinel_q) begin
              next_v = next_v + CNT_W'(1);
            end
          end
          out_valid_d = 1'b1;
          out_value_d = 8'(b_q);
          out_pos_d   = 16'(pos_v);
          out_last_d  = pos_v == '0;
          emit_left_d = pos_v;
          walk_d      = next_v;
          if (pos_v == '0) begin
            phase_d = PH_IDLE;
          end
          state_d = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      phase_q     <= PH_IDLE;
      length_q    <= '0;
      sentinel_q  <= '0;
      walk_q      <= '0;
      emit_left_q <= '0;
      acc_q       <= '0;
      sweep_idx_q <= '0;
      sym_q       <= '0;
      primary_q   <= '0;
      last_q      <= 1'b0;
      b_q         <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      length_q    <= length_d;
      sentinel_q  <= sentinel_d;
      walk_q      <= walk_d;
      emit_left_q <= emit_left_d;
      acc_q       <= acc_d;
      sweep_idx_q <= sweep_idx_d;
      sym_q       <= sym_d;
      primary_q   <= primary_d;
      last_q      <= last_d;
      b_q         <= b_d;
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_pos_q   <= out_pos_d;
      out_last_q  <= out_last_d;
    end
  end

  assign s_axis_tready_o = state_q == ST_READY;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_pos_q, out_value_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: verif/inverse_bwt_block_decoder_top_tb.sv
// Testbench for the inverse BWT block decoder: directed and random load/emit traffic checked against a walk model.
`timescale 1ns / 1ps

typedef enum logic {
  REQ_LOAD,
  REQ_EMIT
} req_kind_e;

typedef enum logic [1:0] {
  BLK_IDLE,
  BLK_LOADING,
  BLK_EMITTING
} blk_phase_e;

typedef enum logic [1:0] {
  RX_OPEN,
  RX_COIN,
  RX_EVERY_THIRD,
  RX_SPARSE
} rx_mode_e;

typedef enum logic [1:0] {
  SYM_FULL,
  SYM_FEW,
  SYM_ZERO_HEAVY
} sym_mix_e;

typedef struct packed {
  logic [7:0]  value;
  logic [15:0] position;
  logic        last;
} out_byte_t;

class ibwt_scoreboard;
  bit [7:0]    row_symbol[ibwt_pkg::BLOCK_MAX];
  int unsigned row_rank[ibwt_pkg::BLOCK_MAX];
  int unsigned symbol_tally[ibwt_pkg::SYMBOLS];
  int unsigned tally_base[ibwt_pkg::SYMBOLS];
  int unsigned blk_len = 0;
  int unsigned primary_row = 0;
  int unsigned walk_row = 0;
  int unsigned bytes_left = 0;
  blk_phase_e  phase = BLK_IDLE;
  out_byte_t   expected_bytes[$];
  int unsigned mismatches = 0;

  // Returns 1 when the request does any work in the block.
  function bit note_request(req_kind_e kind, bit [7:0] sym_in, bit [15:0] primary, bit last);
    int unsigned sym;
    int unsigned acc;
    int unsigned row;
    int unsigned b;
    int unsigned r;
    int unsigned next_row;
    int unsigned pos;
    out_byte_t   res;
    if (kind == REQ_LOAD) begin
      if (phase != BLK_LOADING) begin
        foreach (symbol_tally[s]) begin
          symbol_tally[s] = 0;
          tally_base[s] = 0;
        end
        blk_len = 0;
        bytes_left = 0;
        phase = BLK_LOADING;
      end
      sym = (sym_in >= ibwt_pkg::SYMBOLS) ? ibwt_pkg::SYMBOLS - 1 : sym_in;
      if (blk_len < ibwt_pkg::BLOCK_MAX) begin
        row_symbol[blk_len] = 8'(sym);
        row_rank[blk_len] = symbol_tally[sym];
        symbol_tally[sym]++;
        blk_len++;
      end
      if (last) begin
        if (blk_len == 0) begin
          phase = BLK_IDLE;
        end else begin
          acc = 0;
          foreach (tally_base[s]) begin
            tally_base[s] = acc;
            acc += symbol_tally[s];
          end
          primary_row = (primary < blk_len) ? primary : blk_len - 1;
          walk_row = primary_row;
          bytes_left = blk_len;
          phase = BLK_EMITTING;
        end
      end
      return 1'b1;
    end
    if (phase != BLK_EMITTING) begin
      return 1'b0;
    end
    row = walk_row;
    b = 0;
    r = 0;
    // Rows past the end of the block read as byte zero with rank zero.
    if (row < blk_len) begin
      b = row_symbol[row];
      r = row_rank[row];
    end
    // The primary row holds the sentinel, so zero bytes above it sit one row lower.
    if (row == primary_row) begin
      next_row = 0;
    end else begin
      next_row = r + tally_base[b];
      if (b == 0 && row < primary_row) begin
        next_row++;
      end
    end
    pos = bytes_left - 1;
    bytes_left = pos;
    walk_row = next_row;
    res.value = 8'(b);
    res.position = 16'(pos);
    res.last = (pos == 0);
    expected_bytes.push_back(res);
    if (pos == 0) begin
      phase = BLK_IDLE;
    end
    return 1'b1;
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    if (mismatches < 100) begin
      $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task check_result(bit [7:0] value, bit [15:0] position, bit last);
    out_byte_t want;
    if (expected_bytes.size() == 0) begin
      report("output byte with none expected, position", position, 0);
    end else begin
      want = expected_bytes.pop_front();
      if (value != want.value) begin
        report("value", value, want.value);
      end
      if (position != want.position) begin
        report("position", position, want.position);
      end
      if (last != want.last) begin
        report("last", last, want.last);
      end
    end
  endtask

  function int unsigned pending();
    return expected_bytes.size();
  endfunction
endclass

module inverse_bwt_block_decoder_top_tb;
  import ibwt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          TAIL_CYCLES  = 24;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int          HOLD_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  ibwt_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    burst_left = 0;
  int unsigned    items_sent = 0;
  bit             hold_off_req = 1'b0;

  inverse_bwt_block_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[inverse_bwt_block_decoder_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o[7:0], m_axis_tdata_o[23:8], m_axis_tlast_o);
    end
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned span;
    int unsigned tick;
    m_axis_tready_i = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          m_axis_tready_i = 1'b0;
        end
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          RX_OPEN:        m_axis_tready_i = 1'b1;
          RX_COIN:        m_axis_tready_i = 1'($urandom);
          RX_EVERY_THIRD: m_axis_tready_i = (tick % 3 == 0);
          default:        m_axis_tready_i = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_request(req_kind_e kind, logic [7:0] sym, logic [15:0] primary,
                              logic last);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {primary, sym};
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent += sb.note_request(kind, sym, primary, last);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic load_byte(logic [7:0] sym, logic [15:0] primary, logic last);
    pace();
    send_request(REQ_LOAD, sym, primary, last);
  endtask

  task automatic request_emit();
    pace();
    send_request(REQ_EMIT, 8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    int unsigned block_len;
    int unsigned emit_count;
    int unsigned random_start;
    bit          first_block;
    logic [15:0] prim;
    logic [7:0]  sym;
    sym_mix_e    mix;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = REQ_LOAD;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // An emit request with no decoded block is dropped.
    request_emit();
    // One-byte block whose primary row is far out of range.
    load_byte(8'hFF, 16'hFFFF, 1'b1);
    request_emit();
    request_emit();
    // Zero bytes in the rows ahead of the primary row.
    load_byte(8'h00, 16'h0000, 1'b0);
    load_byte(8'h00, 16'h0000, 1'b0);
    load_byte(8'hFF, 16'h0000, 1'b0);
    load_byte(8'h80, 16'h0002, 1'b1);
    repeat (4) request_emit();
    // Primary row zero; a new block cuts the walk short.
    load_byte(8'h01, 16'h0000, 1'b0);
    load_byte(8'h02, 16'h0000, 1'b0);
    load_byte(8'h03, 16'h0000, 1'b1);
    request_emit();
    load_byte(8'h55, 16'hAAAA, 1'b0);
    load_byte(8'hAA, 16'h0001, 1'b1);
    repeat (3) request_emit();

    first_block = 1'b1;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) request_emit();
      end
      if (first_block) begin
        block_len = 24;
      end else if ($urandom_range(0, 15) == 0) begin
        block_len = $urandom_range(33, 300);
      end else begin
        block_len = $urandom_range(1, 32);
      end
      mix = sym_mix_e'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0:       prim = 16'($urandom);
        1:       prim = 16'h0000;
        2:       prim = 16'(block_len - 1);
        default: prim = 16'($urandom_range(0, block_len - 1));
      endcase
      for (int i = 0; i < block_len; i++) begin
        case (mix)
          SYM_FEW:        sym = 8'($urandom_range(0, 3));
          SYM_ZERO_HEAVY: sym = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
          default:        sym = 8'($urandom);
        endcase
        if (i == block_len - 1) begin
          load_byte(sym, prim, 1'b1);
        end else begin
          load_byte(sym, 16'($urandom), 1'b0);
        end
      end
      case ($urandom_range(0, 9))
        0:       emit_count = $urandom_range(0, block_len - 1);
        1:       emit_count = block_len + $urandom_range(1, 3);
        default: emit_count = block_len;
      endcase
      if (first_block) begin
        // The receiver holds off while emits keep coming, so the output backs up.
        emit_count = block_len;
        hold_off_req = 1'b1;
        first_block = 1'b0;
      end
      repeat (emit_count) request_emit();
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report("results left over", sb.pending(), 0);
    end
    if (sb.mismatches == 0) begin
      $display("[inverse_bwt_block_decoder_top] OK");
    end else begin
      $display("[inverse_bwt_block_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
